// ===== src/ipv4_dotted_decimal_parser_macros.svh =====
// Assertion helpers for the IPv4 parser. Clock is clk and reset is rst in every user.
`ifndef IPV4_DOTTED_DECIMAL_PARSER_MACROS_SVH
`define IPV4_DOTTED_DECIMAL_PARSER_MACROS_SVH

// Same-cycle implication.
`define IPV4DP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define IPV4DP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/ipv4dp_pkg.sv =====
`timescale 1ns / 1ps

package ipv4dp_pkg;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_FORMAT = 2'd1,
    STATUS_OCTET  = 2'd2
  } status_t;

  localparam logic [7:0] CHAR_DOT  = 8'h2E;
  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  localparam logic [8:0] OCTET_MAX = 9'd255;
  localparam logic [8:0] ACC_SAT   = 9'd256;

  // One character beat as held in the input register.
  typedef struct packed {
    logic [7:0] character;
    logic       end_of_text;
  } item_t;

  // One result beat.
  typedef struct packed {
    status_t    status;
    logic [7:0] octet_first;
    logic [7:0] octet_second;
    logic [7:0] octet_third;
    logic [7:0] octet_fourth;
  } result_t;

endpackage

// ===== src/ipv4dp_char_if.sv =====
`timescale 1ns / 1ps

interface ipv4dp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       end_of_text;

  modport source (output valid, output character, output end_of_text, input ready);
  modport sink   (input valid, input character, input end_of_text, output ready);
endinterface

// ===== src/ipv4dp_result_if.sv =====
`timescale 1ns / 1ps

interface ipv4dp_result_if;
  logic                valid;
  logic                ready;
  ipv4dp_pkg::status_t status;
  logic [7:0]          octet_first;
  logic [7:0]          octet_second;
  logic [7:0]          octet_third;
  logic [7:0]          octet_fourth;

  modport source (output valid, output status, output octet_first, output octet_second,
                  output octet_third, output octet_fourth, input ready);
  modport sink   (input valid, input status, input octet_first, input octet_second,
                  input octet_third, input octet_fourth, output ready);
endinterface

// ===== src/ipv4dp_in_stage.sv =====
`timescale 1ns / 1ps

// Input register: holds one character beat until the parser takes it.
module ipv4dp_in_stage (
  input  logic                  clk,
  input  logic                  rst,
  ipv4dp_char_if.sink           chars,
  input  logic                  take,
  output logic                  item_valid,
  output ipv4dp_pkg::item_t     item
);

  logic load;

  assign chars.ready = !item_valid || take;
  assign load        = chars.valid && chars.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (load) begin
      item_valid <= 1'b1;
    end else if (take) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item.character   <= chars.character;
      item.end_of_text <= chars.end_of_text;
    end
  end

endmodule

// ===== src/ipv4dp_core.sv =====
`timescale 1ns / 1ps

// Parse state and the per-character update. One beat per cycle; an end beat waits for a free result register.
module ipv4dp_core (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    item_valid,
  input  ipv4dp_pkg::item_t       item,
  input  logic                    out_free,
  output logic                    take,
  output logic                    res_valid,
  output ipv4dp_pkg::result_t     res
);

  logic [1:0]          octet_index, octet_index_next;
  logic [8:0]          acc, acc_next;
  logic                in_digits, in_digits_next;
  logic                trailer, trailer_next;
  ipv4dp_pkg::status_t err, err_next;
  logic [7:0]          parsed [4];
  logic                oct_wr;

  logic        is_digit, is_line_end, is_dot;
  logic [3:0]  digit;
  logic [12:0] acc_mul;
  logic [8:0]  acc_sat;
  logic [7:0]  last_octet;
  ipv4dp_pkg::status_t status;

  assign take      = item_valid && (!item.end_of_text || out_free);
  assign res_valid = take && item.end_of_text;

  assign is_digit    = (item.character >= ipv4dp_pkg::CHAR_ZERO) &&
                       (item.character <= ipv4dp_pkg::CHAR_NINE);
  assign is_line_end = (item.character == ipv4dp_pkg::CHAR_CR) ||
                       (item.character == ipv4dp_pkg::CHAR_LF);
  assign is_dot      = (item.character == ipv4dp_pkg::CHAR_DOT);
  assign digit       = 4'(item.character - ipv4dp_pkg::CHAR_ZERO);

  // acc * 10 + digit, saturating at 256
  assign acc_mul = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {9'd0, digit};
  assign acc_sat = (acc_mul > 13'(ipv4dp_pkg::ACC_SAT)) ? ipv4dp_pkg::ACC_SAT : acc_mul[8:0];

  always_comb begin
    octet_index_next = octet_index;
    acc_next         = acc;
    in_digits_next   = in_digits;
    trailer_next     = trailer;
    err_next         = err;
    oct_wr           = 1'b0;
    if (take) begin
      if (item.end_of_text) begin
        octet_index_next = 2'd0;
        acc_next         = 9'd0;
        in_digits_next   = 1'b0;
        trailer_next     = 1'b0;
        err_next         = ipv4dp_pkg::STATUS_OK;
      end else if (err == ipv4dp_pkg::STATUS_OK) begin
        if (trailer) begin
          if (!is_line_end) begin
            err_next = ipv4dp_pkg::STATUS_FORMAT;
          end
        end else if (!in_digits) begin
          if (is_digit) begin
            in_digits_next = 1'b1;
            acc_next       = {5'd0, digit};
          end else begin
            err_next = ipv4dp_pkg::STATUS_FORMAT;
          end
        end else if (is_digit) begin
          acc_next = acc_sat;
          if (acc_sat > ipv4dp_pkg::OCTET_MAX) begin
            err_next = ipv4dp_pkg::STATUS_OCTET;
          end
        end else begin
          oct_wr = 1'b1;
          if (octet_index != 2'd3) begin
            if (is_dot) begin
              octet_index_next = octet_index + 2'd1;
              in_digits_next   = 1'b0;
              acc_next         = 9'd0;
            end else begin
              err_next = ipv4dp_pkg::STATUS_FORMAT;
            end
          end else if (is_line_end) begin
            trailer_next   = 1'b1;
            in_digits_next = 1'b0;
          end else begin
            err_next = ipv4dp_pkg::STATUS_FORMAT;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      octet_index <= 2'd0;
      acc         <= 9'd0;
      in_digits   <= 1'b0;
      trailer     <= 1'b0;
      err         <= ipv4dp_pkg::STATUS_OK;
    end else begin
      octet_index <= octet_index_next;
      acc         <= acc_next;
      in_digits   <= in_digits_next;
      trailer     <= trailer_next;
      err         <= err_next;
    end
  end

  always_ff @(posedge clk) begin
    if (oct_wr) begin
      parsed[octet_index] <= acc[7:0];
    end
  end

  // Result for an end beat; octet four may still be in the accumulator.
  always_comb begin
    status     = err;
    last_octet = parsed[3];
    if (err == ipv4dp_pkg::STATUS_OK) begin
      if (trailer) begin
        last_octet = parsed[3];
      end else if (octet_index == 2'd3 && in_digits) begin
        last_octet = acc[7:0];
      end else begin
        status = ipv4dp_pkg::STATUS_FORMAT;
      end
    end
    res.status = status;
    if (status == ipv4dp_pkg::STATUS_OK) begin
      res.octet_first  = parsed[0];
      res.octet_second = parsed[1];
      res.octet_third  = parsed[2];
      res.octet_fourth = last_octet;
    end else begin
      res.octet_first  = 8'd0;
      res.octet_second = 8'd0;
      res.octet_third  = 8'd0;
      res.octet_fourth = 8'd0;
    end
  end

endmodule

// ===== src/ipv4dp_out_reg.sv =====
`timescale 1ns / 1ps

// Result register: holds one result beat until the sink takes it.
module ipv4dp_out_reg (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  res_valid,
  input  ipv4dp_pkg::result_t   res,
  output logic                  out_free,
  ipv4dp_result_if.source       result
);

  ipv4dp_pkg::result_t hold;

  assign out_free = !result.valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (res_valid) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      hold <= res;
    end
  end

  assign result.status       = hold.status;
  assign result.octet_first  = hold.octet_first;
  assign result.octet_second = hold.octet_second;
  assign result.octet_third  = hold.octet_third;
  assign result.octet_fourth = hold.octet_fourth;

endmodule

// ===== src/ipv4_dotted_decimal_parser.sv =====
// IPv4 dotted-decimal parser. Text arrives on the chars channel one character per beat;
// a beat with end_of_text set closes the string and yields exactly one beat on the result
// channel: status (ok, format error, or octet above 255) and the four octets, which are
// zero unless status is ok. The accepted form is X.X.X.X with decimal octets, optionally
// followed by any mix of CR and LF. The first error sticks until the end beat; the
// character field of the end beat is ignored. Throughput is one character per clock but
// for the stall below: the input register feeds a single combinational update of the parse
// state, and the result register lets characters keep flowing while a result waits. The
// result is registered, valid in the cycle after the parser takes the end beat. The only
// stall is an end beat meeting a result still held in the output register.
`timescale 1ns / 1ps

`include "ipv4_dotted_decimal_parser_macros.svh"

module ipv4_dotted_decimal_parser (
  input  logic            clk,
  input  logic            rst,
  ipv4dp_char_if.sink     chars,
  ipv4dp_result_if.source result
);

  // input register -> parser handshake
  logic                item_valid;
  ipv4dp_pkg::item_t   item;
  logic                take;

  // parser -> result register
  logic                res_valid;
  ipv4dp_pkg::result_t res;
  logic                out_free;

  ipv4dp_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .chars      (chars),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  ipv4dp_core u_core (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .out_free   (out_free),
    .take       (take),
    .res_valid  (res_valid),
    .res        (res)
  );

  ipv4dp_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .out_free  (out_free),
    .result    (result)
  );

  // A result is only produced into a free output register.
  `IPV4DP_ASSERT_NOW(a_res_into_free, res_valid, out_free, "result written over a held beat")

  // A held character that was not taken is still there next cycle.
  `IPV4DP_ASSERT_NEXT(a_item_held, item_valid && !take && !chars.ready, item_valid,
                      "input register lost a beat")

  // Error results carry zero octets.
  `IPV4DP_ASSERT_NOW(a_err_zero, result.valid && result.status != ipv4dp_pkg::STATUS_OK,
                     result.octet_first == 8'd0 && result.octet_second == 8'd0 &&
                     result.octet_third == 8'd0 && result.octet_fourth == 8'd0,
                     "error result with nonzero octets")

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import ipv4dp_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  logic clk;
  logic rst;

  ipv4dp_char_if   chars_if();
  ipv4dp_result_if result_if();

  ipv4_dotted_decimal_parser dut (
    .clk    (clk),
    .rst    (rst),
    .chars  (chars_if),
    .result (result_if)
  );

  // Knobs shared between the test tasks and the ready process.
  int sender_idle_pct = 0;   // chance per cycle that the sender holds off
  int recv_stall_pct  = 0;   // chance per cycle that the result sink stalls
  int hold_left       = 0;   // cycles of forced result stall still to run
  int beats_sent      = 0;   // accepted char beats, end beats included
  int mismatch_count  = 0;

  // Expected result beats, oldest first.
  result_t pending_addrs[$];

  // Shadow copy of the parse state, updated per accepted char beat.
  logic [1:0] cur_octet  = '0;
  logic [8:0] acc        = '0;
  bit         in_digits  = 1'b0;
  bit         in_trailer = 1'b0;
  status_t    err        = STATUS_OK;
  logic [7:0] octets[4]  = '{default: '0};

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic bit is_digit(logic [7:0] c);
    return c >= CHAR_ZERO && c <= CHAR_NINE;
  endfunction

  function automatic bit is_line_end(logic [7:0] c);
    return c == CHAR_CR || c == CHAR_LF;
  endfunction

  // One plain character through the parse state.
  function automatic void parse_char(logic [7:0] c);
    int unsigned v;
    // first error sticks; everything after it is ignored
    if (err != STATUS_OK) return;
    if (in_trailer) begin
      if (!is_line_end(c)) err = STATUS_FORMAT;
      return;
    end
    // an octet must open with a digit
    if (!in_digits) begin
      if (is_digit(c)) begin
        in_digits = 1'b1;
        acc       = 9'(c - CHAR_ZERO);
      end else begin
        err = STATUS_FORMAT;
      end
      return;
    end
    // further digits: x10 + d, pinned at 256, flagged past 255
    if (is_digit(c)) begin
      v = acc * 10 + (c - CHAR_ZERO);
      if (v > ACC_SAT) v = ACC_SAT;
      acc = v[8:0];
      if (v > OCTET_MAX) err = STATUS_OCTET;
      return;
    end
    // separator closes the octet
    octets[cur_octet] = acc[7:0];
    if (cur_octet < 2'd3) begin
      if (c == CHAR_DOT) begin
        cur_octet = cur_octet + 2'd1;
        in_digits = 1'b0;
        acc       = '0;
      end else begin
        err = STATUS_FORMAT;
      end
    end else if (is_line_end(c)) begin
      in_trailer = 1'b1;
      in_digits  = 1'b0;
    end else begin
      err = STATUS_FORMAT;
    end
  endfunction

  // End beat: build the result and clear per-string state.
  function automatic result_t close_string();
    result_t r;
    status_t st;
    st = err;
    if (st == STATUS_OK && !in_trailer) begin
      if (cur_octet == 2'd3 && in_digits) octets[3] = acc[7:0];
      else st = STATUS_FORMAT;
    end
    r.status       = st;
    r.octet_first  = (st == STATUS_OK) ? octets[0] : 8'h00;
    r.octet_second = (st == STATUS_OK) ? octets[1] : 8'h00;
    r.octet_third  = (st == STATUS_OK) ? octets[2] : 8'h00;
    r.octet_fourth = (st == STATUS_OK) ? octets[3] : 8'h00;
    cur_octet  = '0;
    acc        = '0;
    in_digits  = 1'b0;
    in_trailer = 1'b0;
    err        = STATUS_OK;
    return r;
  endfunction

  function automatic byte_q_t to_bytes(string s);
    byte_q_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  // Random well-formed address text; with oversize set, one octet goes past 255.
  function automatic byte_q_t make_address(bit oversize);
    byte_q_t t;
    byte_q_t d;
    string   s;
    int      v;
    int      big_at;
    int      n;
    big_at = oversize ? int'($urandom_range(3, 0)) : -1;
    for (int i = 0; i < 4; i++) begin
      v = (i == big_at) ? int'($urandom_range(99999, 256)) : int'($urandom_range(255, 0));
      case ($urandom_range(3, 0))
        0:       s = $sformatf("%02d", v);
        1:       s = $sformatf("%03d", v);
        default: s = $sformatf("%0d", v);
      endcase
      d = to_bytes(s);
      foreach (d[j]) t.push_back(d[j]);
      if (i < 3) t.push_back(CHAR_DOT);
    end
    n = ($urandom_range(1, 0) == 0) ? 0 : int'($urandom_range(3, 1));
    repeat (n) t.push_back(($urandom_range(1, 0) == 0) ? CHAR_CR : CHAR_LF);
    return t;
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  // Offer one char beat from a falling edge; returns at the falling edge after
  // the handshake with valid still high, so the next beat can follow back to back.
  task automatic send_beat(input logic [7:0] c, input logic eot);
    while (sender_idle_pct != 0 && $urandom_range(99, 0) < sender_idle_pct) begin
      chars_if.valid <= 1'b0;
      @(negedge clk);
    end
    chars_if.valid       <= 1'b1;
    chars_if.character   <= c;
    chars_if.end_of_text <= eot;
    do @(posedge clk); while (!chars_if.ready);
    beats_sent++;
    if (eot) pending_addrs.push_back(close_string());
    else parse_char(c);
    @(negedge clk);
  endtask

  // Whole string plus its end beat; the end beat's char field is random junk.
  task automatic send_string(input byte_q_t text);
    foreach (text[i]) send_beat(text[i], 1'b0);
    send_beat(8'($urandom_range(255, 0)), 1'b1);
  endtask

  task automatic send_text(input string s);
    send_string(to_bytes(s));
  endtask

  // Sender goes quiet until every expected result is back.
  task automatic drain_results();
    chars_if.valid <= 1'b0;
    wait (pending_addrs.size() == 0);
    @(negedge clk);
  endtask

  // Result sink: random stalls, or a forced stall stretch counted down here.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      result_if.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      result_if.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  // Result check against the oldest expectation.
  always @(posedge clk) begin
    result_t    want;
    logic [7:0] got_o[4];
    logic [7:0] want_o[4];
    if (!rst && result_if.valid && result_if.ready) begin
      if (pending_addrs.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want   = pending_addrs.pop_front();
        got_o  = '{result_if.octet_first, result_if.octet_second,
                   result_if.octet_third, result_if.octet_fourth};
        want_o = '{want.octet_first, want.octet_second, want.octet_third, want.octet_fourth};
        if (result_if.status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d",
                                    result_if.status, want.status));
        foreach (got_o[i])
          if (got_o[i] !== want_o[i])
            report_mismatch($sformatf("octet %0d got %0d want %0d",
                                      i + 1, got_o[i], want_o[i]));
      end
    end
  end

  task automatic test_valid_addresses();
    send_text("0.0.0.0");
    send_text("255.255.255.255");
    send_text("1.2.3.4\015\012");
    send_text("010.200.003.099\012\015\012");
    // leading zeros never grow the value
    send_text("00000000001.2.3.4");
  endtask

  task automatic test_format_errors();
    send_text("");              // end with nothing before it
    send_text("1.2.3");         // ends before octet four
    send_text("1.2.3.");        // octet four never starts
    send_text(".1.2.3.4");      // no digit at octet start
    send_text("1..2.3.4");
    send_text("1,2.3.4");       // bad separator after octet one
    send_text("25a.1.1.1");
    send_text("1.2.3.4.5");     // dot after octet four
    send_text("1.2.3.4 ");
    send_text("1.2.3.4\015x");  // junk inside the CR/LF trailer
    send_text("1.2.3.4\0125");  // digit inside the trailer
    send_text("\0151.2.3.4");
  endtask

  task automatic test_octet_overflow();
    send_text("256.0.0.0");
    send_text("999.1.1.1");
    send_text("1.2.3.9999");    // later digits after the error are ignored
    send_text("1.300x.2.3");    // overflow wins over the later bad char
  endtask

  // A zero byte without the end flag is just another bad character.
  task automatic test_nul_character();
    byte_q_t t;
    t = to_bytes("1.2");
    t.push_back(8'h00);
    foreach (t[i]) send_beat(t[i], 1'b0);
    send_text(".3.4");
  endtask

  // Sink holds off for a long stretch while strings keep coming: the output
  // register fills and the next end beat must wait at the input.
  task automatic test_backpressure();
    drain_results();
    @(posedge clk);
    hold_left = 120;
    @(negedge clk);
    sender_idle_pct = 0;
    repeat (6) send_string(make_address(1'b0));
    send_text("7.8.9.10");
  endtask

  // Sender waits for every result before the next string.
  task automatic test_drain_pause();
    repeat (3) begin
      drain_results();
      send_string(make_address(1'b0));
    end
  endtask

  // Mostly well-formed addresses with random content, the rest broken or noise.
  task automatic test_random_phase(input int idle_pct, input int stall_pct,
                                   input int beat_goal);
    byte_q_t t;
    int      k;
    int      pos;
    drain_results();
    sender_idle_pct = idle_pct;
    recv_stall_pct  = stall_pct;
    while (beats_sent < beat_goal) begin
      k = $urandom_range(99, 0);
      if (k < 55) begin
        t = make_address(1'b0);
      end else if (k < 70) begin
        t = make_address(1'b1);
      end else if (k < 90) begin
        t   = make_address(1'b0);
        pos = $urandom_range(t.size() - 1, 0);
        case ($urandom_range(3, 0))
          0: t[pos] = 8'($urandom_range(255, 0));
          1: t.delete(pos);
          2: while (t.size() > pos) void'(t.pop_back());
          default: t.insert(pos, 8'($urandom_range(255, 0)));
        endcase
      end else begin
        t.delete();
        repeat ($urandom_range(10, 0)) begin
          if ($urandom_range(1, 0) == 0) t.push_back(8'($urandom_range(255, 0)));
          else t.push_back(8'($urandom_range(CHAR_NINE, CHAR_ZERO)));
        end
      end
      send_string(t);
    end
  endtask

  initial begin
    rst                  = 1'b1;
    chars_if.valid       = 1'b0;
    chars_if.character   = 8'h00;
    chars_if.end_of_text = 1'b0;
    result_if.ready      = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_valid_addresses();
    test_format_errors();
    test_octet_overflow();
    test_nul_character();
    test_backpressure();
    test_drain_pause();

    // idling phases: none, sender only, sink only, both lightly
    test_random_phase(0, 0, beats_sent + 80);
    test_random_phase(78, 0, beats_sent + 75);
    test_random_phase(0, 78, beats_sent + 75);
    test_random_phase(10, 10, beats_sent + 75);

    drain_results();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && pending_addrs.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // Hard stop well past the slowest correct run.
  initial begin
    #5ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
